FILE: src/edd_pkg.sv
package edd_pkg;

    // Field and register widths
    localparam int GREY_W       = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int DIM_W        = 13;

    // Error term widths (signed two's complement)
    localparam int DIAG_W  = 4;
    localparam int ABOVE_W = 7;
    localparam int UPR_W   = 6;
    localparam int RIGHT_W = 7;
    localparam int PROD_W  = 11;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [GREY_W-1:0] GREY_THRESHOLD = 8'd127;
    localparam logic [GREY_W-1:0] GREY_WHITE     = 8'd255;

    // Position flags of one pixel, worked out by the front
    typedef struct packed {
        logic last_col;
        logic last_row;
    } edd_pos_t;

    // One line store entry: 1/16, 5/16 and 3/16 terms for the next line
    typedef struct packed {
        logic [DIAG_W-1:0]  diag;
        logic [ABOVE_W-1:0] above;
        logic [UPR_W-1:0]   upr;
    } edd_terms_t;

    // One result request
    typedef struct packed {
        logic dot;
        logic line_end;
        logic frame_end;
    } edd_result_t;

    // Add a signed term to a grey level and clamp to 0..255
    function automatic logic [GREY_W-1:0] sat_add(input logic [GREY_W-1:0] v,
                                                   input logic [GREY_W-1:0] t);
        logic signed [GREY_W+1:0] s;
        s = $signed({2'b00, v}) + $signed({{2{t[GREY_W-1]}}, t});
        if (s < 0) begin
            return '0;
        end
        else if (s > $signed({2'b00, GREY_WHITE})) begin
            return GREY_WHITE;
        end
        else begin
            return s[GREY_W-1:0];
        end
    endfunction

endpackage

FILE: src/edd_ram.sv
module edd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port, registered read port (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

FILE: src/edd_queue.sv
module edd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           data_in,
    input  logic                       pop,
    output logic [WIDTH-1:0]           data_out,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign count    = count_reg;
    assign data_out = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

FILE: src/edd_front.sv
module edd_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [edd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                push,
    input  logic [edd_pkg::GREY_W-1:0]          grey_in,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [$clog2(MAX_WIDTH)+edd_pkg::GREY_W+1:0] q_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DIM_W = edd_pkg::DIM_W;
    localparam int RW    = edd_pkg::HEIGHT_REG_W;

    logic [edd_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [edd_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [CW-1:0]                    col_reg, col_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic [DIM_W-1:0]                 w_eff, h_eff;
    logic                             accept;
    edd_pkg::edd_pos_t                pos;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;
    assign q_push    = accept;
    assign q_data    = {pos, grey_in, col_reg};

    // Clamp the frame size to what the line store covers
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DIM_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? DIM_W'(1) : DIM_W'(height_reg);
    end

    // Classify the pixel and step the raster position
    always_comb
    begin
        pos.last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= w_eff;
        pos.last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= h_eff;
        col_next     = col_reg;
        row_next     = row_reg;
        if (accept)
        begin
            if (pos.last_col)
            begin
                col_next = '0;
                row_next = pos.last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= edd_pkg::WIDTH_RESET;
            height_reg <= edd_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    edd_pkg::REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data[edd_pkg::WIDTH_REG_W-1:0];
                    end
                    edd_pkg::REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data[edd_pkg::HEIGHT_REG_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: src/edd_back.sv
module edd_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int OUT_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [$clog2(MAX_WIDTH)+edd_pkg::GREY_W+1:0] q_data,
    output logic                                q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
    output logic                                out_push,
    output edd_pkg::edd_result_t                out_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int GW     = edd_pkg::GREY_W;
    localparam int OCW    = $clog2(OUT_DEPTH + 1);
    localparam int TW     = $bits(edd_pkg::edd_terms_t);
    localparam int PW     = edd_pkg::PROD_W;
    localparam int DIAG_W = edd_pkg::DIAG_W;
    localparam int ABV_W  = edd_pkg::ABOVE_W;
    localparam int UPR_W  = edd_pkg::UPR_W;
    localparam int RGT_W  = edd_pkg::RIGHT_W;

    // Queue word fields
    edd_pkg::edd_pos_t    q_pos;
    logic [GW-1:0]        q_grey;
    logic [CW-1:0]        q_col;

    // Read stage
    logic                 r_valid_reg, r_valid_next;
    logic [GW-1:0]        r_grey_reg;
    logic [CW-1:0]        r_col_reg;
    edd_pkg::edd_pos_t    r_pos_reg;
    logic                 r_load, advance, credit_ok;

    // Evaluate stage
    logic                 x_valid_reg;
    logic [GW-1:0]        x_grey_reg;
    logic [CW-1:0]        x_col_reg;
    edd_pkg::edd_pos_t    x_pos_reg;
    logic                 byp_hit_reg;
    edd_pkg::edd_terms_t  byp_data_reg;
    logic                 ram_ok_reg;

    // Diffusion state
    logic                 pend_valid_reg, pend_valid_next;
    logic [CW-1:0]        pend_addr_reg, pend_addr_next;
    logic [DIAG_W-1:0]    pend_diag_reg, pend_diag_next;
    logic [ABV_W-1:0]     pend_above_reg, pend_above_next;
    logic [DIAG_W-1:0]    diag_carry_reg, diag_carry_next;
    logic [RGT_W-1:0]     right_reg, right_next;
    logic [CW:0]          hwm_reg, hwm_next;

    // Line store ports
    logic                 ram_wr_en;
    logic [CW-1:0]        ram_wr_addr;
    edd_pkg::edd_terms_t  ram_wr_data;
    logic [TW-1:0]        ram_rd_data;
    edd_pkg::edd_terms_t  ram_word, ram_terms;

    // Datapath
    logic                 pend_hit;
    logic [DIAG_W-1:0]    t_diag;
    logic [ABV_W-1:0]     t_above;
    logic [UPR_W-1:0]     t_upr;
    logic [GW-1:0]        v1, v2, v3, v4;
    logic                 white;
    logic [GW-1:0]        err;
    logic signed [PW-1:0] err_x, p3, p5, p7, q1, q3, q5, q7;

    assign {q_pos, q_grey, q_col} = q_data;

    // Hold a pixel in the read stage until the output queue has room for it
    assign credit_ok    = ({1'b0, out_count} + (OCW+1)'(x_valid_reg)) < (OCW+1)'(OUT_DEPTH);
    assign advance      = r_valid_reg && credit_ok;
    assign r_load       = !q_empty && (!r_valid_reg || advance);
    assign q_pop        = r_load;
    assign r_valid_next = r_load || (r_valid_reg && !advance);

    edd_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (r_col_reg),
        .rd_data (ram_rd_data)
    );

    assign ram_word = ram_rd_data;

    // Pick the freshest copy of the column's terms
    always_comb
    begin
        ram_terms = byp_hit_reg ? byp_data_reg : (ram_ok_reg ? ram_word : '0);
        pend_hit  = pend_valid_reg && (pend_addr_reg == x_col_reg);
        t_diag    = pend_hit ? pend_diag_reg  : ram_terms.diag;
        t_above   = pend_hit ? pend_above_reg : ram_terms.above;
        t_upr     = pend_hit ? '0             : ram_terms.upr;
    end

    // Add terms in order, threshold, and split the error
    always_comb
    begin
        v1    = edd_pkg::sat_add(x_grey_reg, {{(GW-DIAG_W){t_diag[DIAG_W-1]}}, t_diag});
        v2    = edd_pkg::sat_add(v1, {{(GW-ABV_W){t_above[ABV_W-1]}}, t_above});
        v3    = edd_pkg::sat_add(v2, {{(GW-UPR_W){t_upr[UPR_W-1]}}, t_upr});
        v4    = edd_pkg::sat_add(v3, {{(GW-RGT_W){right_reg[RGT_W-1]}}, right_reg});
        white = v4 > edd_pkg::GREY_THRESHOLD;
        err   = white ? (v4 - edd_pkg::GREY_WHITE) : v4;
        err_x = $signed({{(PW-GW){err[GW-1]}}, err});
        p3    = (err_x <<< 1) + err_x;
        p5    = (err_x <<< 2) + err_x;
        p7    = (err_x <<< 3) - err_x;
        q1    = err_x >>> 4;
        q3    = p3 >>> 4;
        q5    = p5 >>> 4;
        q7    = p7 >>> 4;
    end

    // Commit the previous column's entry; open this column's entry
    always_comb
    begin
        ram_wr_en         = x_valid_reg && pend_valid_reg;
        ram_wr_addr       = pend_addr_reg;
        ram_wr_data.diag  = pend_diag_reg;
        ram_wr_data.above = pend_above_reg;
        ram_wr_data.upr   = ((x_col_reg != '0) && !x_pos_reg.last_row) ? q3[UPR_W-1:0] : '0;

        pend_valid_next   = pend_valid_reg;
        pend_addr_next    = pend_addr_reg;
        pend_diag_next    = pend_diag_reg;
        pend_above_next   = pend_above_reg;
        diag_carry_next   = diag_carry_reg;
        right_next        = right_reg;
        hwm_next          = hwm_reg;

        if (x_valid_reg)
        begin
            pend_valid_next = 1'b1;
            pend_addr_next  = x_col_reg;
            pend_diag_next  = x_pos_reg.last_row ? '0 : diag_carry_reg;
            pend_above_next = x_pos_reg.last_row ? '0 : q5[ABV_W-1:0];
            diag_carry_next = x_pos_reg.last_col ? '0 : q1[DIAG_W-1:0];
            right_next      = x_pos_reg.last_col ? '0 : q7[RGT_W-1:0];
        end
        if (ram_wr_en && ({1'b0, ram_wr_addr} == hwm_reg))
        begin
            hwm_next = hwm_reg + (CW+1)'(1);
        end
    end

    assign out_push           = x_valid_reg;
    assign out_data.dot       = white;
    assign out_data.line_end  = x_pos_reg.last_col;
    assign out_data.frame_end = x_pos_reg.last_col && x_pos_reg.last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg    <= 1'b0;
            x_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            diag_carry_reg <= '0;
            right_reg      <= '0;
            hwm_reg        <= '0;
        end
        else
        begin
            r_valid_reg    <= r_valid_next;
            x_valid_reg    <= advance;
            pend_valid_reg <= pend_valid_next;
            diag_carry_reg <= diag_carry_next;
            right_reg      <= right_next;
            hwm_reg        <= hwm_next;
        end
    end

    // Payload: stage data, bypass of a write that lands with the read
    always_ff @(posedge clk)
    begin
        if (r_load)
        begin
            r_grey_reg <= q_grey;
            r_col_reg  <= q_col;
            r_pos_reg  <= q_pos;
        end
        if (advance)
        begin
            x_grey_reg <= r_grey_reg;
            x_col_reg  <= r_col_reg;
            x_pos_reg  <= r_pos_reg;
        end
        byp_hit_reg    <= ram_wr_en && (ram_wr_addr == r_col_reg);
        byp_data_reg   <= ram_wr_data;
        ram_ok_reg     <= {1'b0, r_col_reg} < hwm_reg;
        pend_addr_reg  <= pend_addr_next;
        pend_diag_reg  <= pend_diag_next;
        pend_above_reg <= pend_above_next;
    end

    // A result never meets a full output queue
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid_reg |-> (out_count < OCW'(OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    // Within a line the open entry belongs to the column just before
    a_pend_order: assert property (@(posedge clk) disable iff (!rst_n)
        (x_valid_reg && pend_valid_reg && (x_col_reg != '0))
            |-> (pend_addr_reg == (x_col_reg - CW'(1))))
        else $error("open line store entry out of column order");

    // Line store writes only extend the written prefix
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ({1'b0, ram_wr_addr} <= hwm_reg))
        else $error("line store write beyond the filled prefix");

endmodule

FILE: src/error_diffusion_dither_1bit.sv
// 1-bit error-diffusion ditherer: 8-bit grey pixels enter in raster order
// through a push/full queue port and one black/white dot per pixel leaves
// through an empty/pop queue port, marked with the end of its line and of its
// frame. The block takes one pixel per clock when the result side keeps
// popping; a pixel passes the pixel queue, the read stage and the evaluate
// stage before its dot enters the result queue. The pixel rate is set by
// the error loop in the back end, where one pixel's error is registered and
// feeds the next pixel's 7/16 term, and by the line store, a single RAM
// written once and read once per pixel. The line store
// needs no clearing pass after reset: a fill mark makes columns never
// written read as zero, so pixels are taken as soon as reset is released.
// Write image_width (index 0) and image_height (index 1) only while no pixel
// is in flight; widths above MAX_WIDTH are treated as MAX_WIDTH.
module error_diffusion_dither_1bit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [edd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [edd_pkg::GREY_W-1:0]      grey_in,
    output logic                            empty,
    input  logic                            pop,
    output logic                            dot,
    output logic                            line_end,
    output logic                            frame_end
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int QW        = CW + edd_pkg::GREY_W + 2;
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int RES_W     = $bits(edd_pkg::edd_result_t);

    logic                              fq_push, fq_pop, fq_empty;
    logic [QW-1:0]                     fq_data_in, fq_data_out;
    logic                              oq_push;
    edd_pkg::edd_result_t              oq_data_in, oq_head;
    logic [RES_W-1:0]                  oq_data_out;
    logic [$clog2(OUT_DEPTH+1)-1:0]    oq_count;

    edd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .grey_in   (grey_in),
        .q_full    (full),
        .q_push    (fq_push),
        .q_data    (fq_data_in)
    );

    // Pixel queue between front and back
    edd_queue #(
        .WIDTH (QW),
        .DEPTH (MID_DEPTH)
    ) u_pixel_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .data_in  (fq_data_in),
        .pop      (fq_pop),
        .data_out (fq_data_out),
        .empty    (fq_empty),
        .full     (full),
        .count    ()
    );

    edd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (fq_empty),
        .q_data    (fq_data_out),
        .q_pop     (fq_pop),
        .out_count (oq_count),
        .out_push  (oq_push),
        .out_data  (oq_data_in)
    );

    // Result queue toward the consumer
    edd_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (oq_push),
        .data_in  (oq_data_in),
        .pop      (pop),
        .data_out (oq_data_out),
        .empty    (empty),
        .full     (),
        .count    (oq_count)
    );

    assign oq_head   = oq_data_out;
    assign dot       = oq_head.dot;
    assign line_end  = oq_head.line_end;
    assign frame_end = oq_head.frame_end;

endmodule

FILE: test/error_diffusion_dither_1bit_tb.sv
module error_diffusion_dither_1bit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX = 1024;
    localparam int DOT_LATENCY = 6;

    localparam int GREY_W       = edd_pkg::GREY_W;
    localparam int CFG_INDEX_W  = edd_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = edd_pkg::CFG_DATA_W;
    localparam int WIDTH_REG_W  = edd_pkg::WIDTH_REG_W;
    localparam int HEIGHT_REG_W = edd_pkg::HEIGHT_REG_W;
    localparam int DIAG_W       = edd_pkg::DIAG_W;
    localparam int ABOVE_W      = edd_pkg::ABOVE_W;
    localparam int UPR_W        = edd_pkg::UPR_W;
    localparam int RIGHT_W      = edd_pkg::RIGHT_W;

    // Register indexes that the block must ignore
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // Predicts one dot per pixel and checks the dots that come out
    class dither_checker;
        logic signed [DIAG_W-1:0]  diag_terms  [LINE_MAX];
        logic signed [ABOVE_W-1:0] above_terms [LINE_MAX];
        logic signed [UPR_W-1:0]   upr_terms   [LINE_MAX];
        logic signed [RIGHT_W-1:0] left_carry;
        logic signed [DIAG_W-1:0]  diag_carry;
        logic [9:0]                col_pos;
        logic [11:0]               row_pos;
        logic [WIDTH_REG_W-1:0]    width_reg;
        logic [HEIGHT_REG_W-1:0]   height_reg;
        edd_pkg::edd_result_t      expected_dots [$];
        int                        errors;
        int                        pixels;
        int                        lines;
        int                        frames;
        int                        reg_writes;

        function new();
            for (int c = 0; c < LINE_MAX; c++)
            begin
                diag_terms[c]  = '0;
                above_terms[c] = '0;
                upr_terms[c]   = '0;
            end
            left_carry = '0;
            diag_carry = '0;
            col_pos    = '0;
            row_pos    = '0;
            width_reg  = edd_pkg::WIDTH_RESET;
            height_reg = edd_pkg::HEIGHT_RESET;
            errors     = 0;
            pixels     = 0;
            lines      = 0;
            frames     = 0;
            reg_writes = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == edd_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg = data[WIDTH_REG_W-1:0];
            end
            else if (idx == edd_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg = data[HEIGHT_REG_W-1:0];
            end
        endfunction

        function int clamp_add(int level, int term);
            int s;
            s = level + term;
            if (s < 0)
            begin
                return 0;
            end
            if (s > 255)
            begin
                return 255;
            end
            return s;
        endfunction

        // Error share e*k/16, rounded toward minus infinity
        function int error_share(int e, int k);
            int p;
            p = e * k;
            return p >>> 4;
        endfunction

        function int outstanding();
            return expected_dots.size();
        endfunction

        function void note_pixel(logic [GREY_W-1:0] grey);
            int                   w;
            int                   h;
            int                   c;
            int                   r;
            int                   v;
            int                   e;
            logic                 last_col;
            logic                 last_row;
            logic                 white;
            edd_pkg::edd_result_t res;
            w = width_reg;
            h = height_reg;
            c = col_pos;
            r = row_pos;
            if (w < 1)
            begin
                w = 1;
            end
            if (w > LINE_MAX)
            begin
                w = LINE_MAX;
            end
            if (h < 1)
            begin
                h = 1;
            end
            last_col = (c + 1 >= w);
            last_row = (r + 1 >= h);

            // Add the upper-left, above, upper-right and left terms in turn
            v = grey;
            v = clamp_add(v, diag_terms[c]);
            v = clamp_add(v, above_terms[c]);
            v = clamp_add(v, upr_terms[c]);
            v = clamp_add(v, left_carry);
            white = (v > 127);
            e = white ? v - 255 : v;

            // Spread the error to the next line, or clear it on the last line
            if (!last_row)
            begin
                if (c > 0)
                begin
                    upr_terms[c-1] = UPR_W'(error_share(e, 3));
                end
                diag_terms[c]  = diag_carry;
                above_terms[c] = ABOVE_W'(error_share(e, 5));
                upr_terms[c]   = '0;
            end
            else
            begin
                diag_terms[c]  = '0;
                above_terms[c] = '0;
                upr_terms[c]   = '0;
            end
            diag_carry = DIAG_W'(error_share(e, 1));
            left_carry = RIGHT_W'(error_share(e, 7));

            // Advance the raster position
            if (last_col)
            begin
                diag_carry = '0;
                left_carry = '0;
                col_pos    = '0;
                row_pos    = last_row ? 12'd0 : row_pos + 12'd1;
            end
            else
            begin
                col_pos = 10'(c + 1);
            end

            res.dot       = white;
            res.line_end  = last_col;
            res.frame_end = last_col && last_row;
            expected_dots.push_back(res);
            pixels++;
            lines  += last_col;
            frames += last_col && last_row;
        endfunction

        function void check_dot(logic got_dot, logic got_line_end, logic got_frame_end);
            edd_pkg::edd_result_t want;
            if (expected_dots.size() == 0)
            begin
                errors++;
                $display("%0t: dot expected none actual %0b", $time, got_dot);
                return;
            end
            want = expected_dots.pop_front();
            if (got_dot !== want.dot)
            begin
                errors++;
                $display("%0t: dot expected %0b actual %0b", $time, want.dot, got_dot);
            end
            if (got_line_end !== want.line_end)
            begin
                errors++;
                $display("%0t: line_end expected %0b actual %0b",
                         $time, want.line_end, got_line_end);
            end
            if (got_frame_end !== want.frame_end)
            begin
                errors++;
                $display("%0t: frame_end expected %0b actual %0b",
                         $time, want.frame_end, got_frame_end);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    push      = 1'b0;
    logic                    full;
    logic [GREY_W-1:0]       grey_in   = '0;
    logic                    empty;
    logic                    pop       = 1'b0;
    logic                    dot;
    logic                    line_end;
    logic                    frame_end;

    dither_checker sb = new();
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            recv_hold_len = 0;
    int            full_stalls   = 0;

    error_diffusion_dither_1bit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .grey_in   (grey_in),
        .empty     (empty),
        .pop       (pop),
        .dot       (dot),
        .line_end  (line_end),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample both request sides at the edge and feed the checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sb.note_pixel(grey_in);
            end
            if (push && full)
            begin
                full_stalls++;
            end
            if (pop && !empty)
            begin
                sb.check_dot(dot, line_end, frame_end);
            end
        end
    end

    // Result side: random pops, or a long hold-off when asked for one
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_hold_len > 0)
            begin
                pop <= 1'b0;
                for (int i = 0; i < recv_hold_len; i++)
                begin
                    @(posedge clk);
                end
                recv_hold_len = 0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_pixel(input logic [GREY_W-1:0] grey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push    <= 1'b0;
            grey_in <= GREY_W'($urandom);
            @(posedge clk);
        end
        push    <= 1'b1;
        grey_in <= grey;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
    endtask

    // Hold the input until every dot has come out and the pipe is quiet
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DOT_LATENCY) @(posedge clk);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] width_data,
                            input logic [CFG_DATA_W-1:0] height_data);
        write_reg(edd_pkg::REG_IMAGE_WIDTH, width_data);
        write_reg(edd_pkg::REG_IMAGE_HEIGHT, height_data);
        if ($urandom_range(4) == 0)
        begin
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // Greys biased toward the threshold and the rails
    function automatic logic [GREY_W-1:0] random_grey();
        case ($urandom_range(9)) inside
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            [4:5]: return GREY_W'($urandom_range(100, 160));
            default: return GREY_W'($urandom);
        endcase
    endfunction

    task automatic run_segment(input logic [CFG_DATA_W-1:0] width_data,
                               input logic [CFG_DATA_W-1:0] height_data,
                               input int count);
        wait_drained();
        set_size(width_data, height_data);
        repeat (count) push_pixel(random_grey());
    endtask

    initial
    begin
        logic [GREY_W-1:0] opening [12];
        int                w;
        int                h;
        opening = '{8'd127, 8'd127, 8'd128, 8'd128, 8'd255, 8'd255,
                    8'd0, 8'd0, 8'd128, 8'd127, 8'd255, 8'd0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size, then shrink mid-line so the current column ends the line
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd127);
        wait_drained();
        set_size(12'd4, 12'd3);
        foreach (opening[i])
        begin
            push_pixel(opening[i]);
        end

        // Single-pixel frames, then zero sizes and the spare indexes
        wait_drained();
        set_size(12'd1, 12'd1);
        push_pixel(8'd128);
        push_pixel(8'd127);
        wait_drained();
        write_reg(REG_SPARE_A, 12'hFFF);
        write_reg(REG_SPARE_B, 12'hFFF);
        write_reg(edd_pkg::REG_IMAGE_WIDTH, 12'd0);
        write_reg(edd_pkg::REG_IMAGE_HEIGHT, 12'd0);
        cfg_valid <= 1'b0;
        push_pixel(8'd200);
        push_pixel(8'd60);

        // Random frames under three idle mixes
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 53 : 0;
            recv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 25 : 0;
            for (int seg = 0; seg < 6; seg++)
            begin
                w = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(1, 12);
                h = $urandom_range(6);
                run_segment({1'($urandom_range(1)), w[WIDTH_REG_W-1:0]}, 12'(h),
                            $urandom_range(10, 40));
            end
        end

        // Back up the result side so the block fills and stalls its input
        wait_drained();
        recv_hold_len = 300;
        run_segment(12'd8, 12'd4, 150);

        // Over-range width and the largest height, with all register bits set
        run_segment(12'hFFF, 12'hFFF, 120);

        wait_drained();
        $display("Checked %0d pixels: %0d lines, %0d frames, %0d register writes",
                 sb.pixels, sb.lines, sb.frames, sb.reg_writes);
        $display("Widths 0..64 and over range, heights 0..6 and 4095, three idle mixes, %0d %s",
                 full_stalls, "cycles stalled on full");
        if (sb.errors == 0)
        begin
            $display("error_diffusion_dither_1bit_tb OK");
        end
        else
        begin
            $display("error_diffusion_dither_1bit_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("Timeout with %0d dots still pending", sb.outstanding());
        $display("error_diffusion_dither_1bit_tb NOT OK");
        $finish;
    end

endmodule
